/* src/bpdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpdc_pkg
// Shared widths, register indexes and reset values of the button press
// duration classifier.
// ----------------------------------------------------------------------------
package bpdc_pkg;

    localparam int TIME_W      = 32;
    localparam int LIMIT_W     = 16;
    localparam int TOTAL_W     = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 16;

    // stream payload widths, rounded up to whole bytes
    localparam int IN_BITS     = 1 + TIME_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 6 + TOTAL_W + TIME_W + TIME_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LEVEL  = 4'd0,
        CFG_MIN_PRESS     = 4'd1,
        CFG_FIRST_LIMIT   = 4'd2,
        CFG_SECOND_LIMIT  = 4'd3
    } t_cfg_idx;

    localparam logic               RST_ACTIVE_LEVEL = 1'b1;
    localparam logic [LIMIT_W-1:0] RST_MIN_PRESS    = 16'd50;
    localparam logic [LIMIT_W-1:0] RST_FIRST_LIMIT  = 16'd1000;
    localparam logic [LIMIT_W-1:0] RST_SECOND_LIMIT = 16'd5000;

    // one result item
    typedef struct packed {
        logic [TIME_W-1:0]  time_in_state_ms;
        logic [TIME_W-1:0]  last_press_ms;
        logic [TOTAL_W-1:0] press_total;
        logic               release_over_second;
        logic               release_over_first;
        logic               release_valid;
        logic               held_over_second;
        logic               held_over_first;
        logic               is_pressed;
    } t_result;

endpackage

/* src/button_press_duration_classifier_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_duration_classifier_top
// Classifies button presses by duration from timestamped pin samples.
// ----------------------------------------------------------------------------
// Takes one pin sample with its millisecond timestamp per item and returns one
// result item per sample. Throughput is one item per clock while the output
// is not stalled; an input register feeds the result register, with the press
// state updated by a single subtract-and-compare stage between them. The
// result register is held while m_axis_tready is low and the input side keeps
// accepting as long as the result register is free or being drained.
// Configuration writes take effect at once and are accepted in every cycle.
module button_press_duration_classifier_top
    import bpdc_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [0] pin_level, [32:1] now_ms, rest zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] is_pressed, [1] held_over_first, [2] held_over_second,
    // [3] release_valid, [4] release_over_first, [5] release_over_second,
    // [21:6] press_total, [53:22] last_press_ms, [85:54] time_in_state_ms,
    // rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // configuration
    logic               r_active_level;
    logic [LIMIT_W-1:0] r_min_press;
    logic [LIMIT_W-1:0] r_first_limit;
    logic [LIMIT_W-1:0] r_second_limit;

    // input register
    logic              r_in_valid;
    logic              r_pin;
    logic [TIME_W-1:0] r_now;

    // press state
    logic                  r_held;
    logic [TIME_W-1:0]     r_edge_time;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [TIME_W-1:0]     r_press_len;
    logic [1:0]            r_hold;
    logic [2:0]            r_rel;

    logic                  n_held;
    logic [TIME_W-1:0]     n_edge_time;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [TIME_W-1:0]     n_press_len;
    logic [1:0]            n_hold;
    logic [2:0]            n_rel;

    // result register
    logic    r_out_valid;
    t_result r_out;
    t_result w_res;

    logic              w_out_free;
    logic              w_adv;
    logic              w_hit;
    logic [TIME_W-1:0] w_el;
    logic              w_over_min;
    logic              w_over_first;
    logic              w_over_second;
    logic [TIME_W-1:0] w_cnt_ext;

    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    assign w_hit         = (r_pin == r_active_level);
    assign w_el          = r_now - r_edge_time;
    assign w_over_min    = w_el > TIME_W'(r_min_press);
    assign w_over_first  = w_el > TIME_W'(r_first_limit);
    assign w_over_second = w_el > TIME_W'(r_second_limit);

    always_comb begin
        n_held      = r_held;
        n_edge_time = r_edge_time;
        n_cnt       = r_cnt;
        n_press_len = r_press_len;
        n_hold      = r_hold;
        n_rel       = r_rel;
        if (w_hit) begin
            if (!r_held) begin
                // press edge
                n_held      = 1'b1;
                n_rel       = 3'b000;
                n_cnt       = r_cnt + COUNT_BITS'(1);
                n_edge_time = r_now;
            end else begin
                n_hold = r_hold | {w_over_second, w_over_first};
            end
        end else begin
            if (r_held) begin
                // release edge
                n_held      = 1'b0;
                n_hold      = 2'b00;
                n_press_len = w_el;
                n_edge_time = r_now;
                if (w_over_min) begin
                    n_rel = {w_over_second, w_over_first, 1'b1};
                end else begin
                    n_cnt = r_cnt - COUNT_BITS'(1);
                end
            end else begin
                n_rel = 3'b000;
            end
        end
    end

    assign w_cnt_ext = TIME_W'(n_cnt);

    always_comb begin
        w_res.is_pressed          = n_held;
        w_res.held_over_first     = n_hold[0];
        w_res.held_over_second    = n_hold[1];
        w_res.release_valid       = n_rel[0];
        w_res.release_over_first  = n_rel[1];
        w_res.release_over_second = n_rel[2];
        w_res.press_total         = w_cnt_ext[TOTAL_W-1:0];
        w_res.last_press_ms       = n_press_len;
        // edge time moved to now on either edge
        w_res.time_in_state_ms    = (n_edge_time == r_edge_time) ? w_el : '0;
        if (w_hit != r_held) begin
            w_res.time_in_state_ms = '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= RST_ACTIVE_LEVEL;
            r_min_press    <= RST_MIN_PRESS;
            r_first_limit  <= RST_FIRST_LIMIT;
            r_second_limit <= RST_SECOND_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_LEVEL: r_active_level <= i_cfg_data[0];
                CFG_MIN_PRESS:    r_min_press    <= i_cfg_data[LIMIT_W-1:0];
                CFG_FIRST_LIMIT:  r_first_limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_SECOND_LIMIT: r_second_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_pin <= s_axis_tdata[0];
            r_now <= s_axis_tdata[TIME_W:1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= 1'b0;
            r_edge_time <= '0;
            r_cnt       <= '0;
            r_press_len <= '0;
            r_hold      <= 2'b00;
            r_rel       <= 3'b000;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (w_adv) begin
                r_held      <= n_held;
                r_edge_time <= n_edge_time;
                r_cnt       <= n_cnt;
                r_press_len <= n_press_len;
                r_hold      <= n_hold;
                r_rel       <= n_rel;
            end
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    // hold flags only live while the button is held
    a_hold_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hold != 2'b00) |-> r_held)
        else $error("hold flag set while released");

    // release pulse only on a released sample
    a_rel_not_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rel[0] |-> !r_held)
        else $error("release pulse while held");

    // over marks come only with a release pulse
    a_rel_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rel[1] || r_rel[2]) |-> r_rel[0])
        else $error("release mark without release pulse");

    // press state moves only when an item is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_cnt) && $stable(r_edge_time) && $stable(r_held)))
        else $error("press state changed without an item");

    // a stalled result keeps its item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result item lost");

endmodule

/* tb/button_press_duration_classifier_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_duration_classifier_top_test
// Self-checking bench for the button press duration classifier. Timestamped
// pin samples go in on the slave stream; each result item on the master stream
// is checked field by field against a tracker that follows the press state.
// A directed run walks the threshold, wrap and short-press corners. Random
// press sequences then run under several register settings and idle/stall
// patterns.
// ----------------------------------------------------------------------------
module button_press_duration_classifier_top_test;
    import bpdc_pkg::*;

    localparam int CYCLE_LIMIT      = 800000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int RANDOM_PER_PHASE = 182;
    localparam int RANDOM_PHASES    = 8;
    localparam int SPARE_IDX_LO     = int'(CFG_SECOND_LIMIT) + 1;
    localparam int SPARE_IDX_HI     = (1 << CFG_IDX_W) - 1;
    localparam int MAX_PRINTED      = 30;

    // follows the classifier state and holds the results still to come
    class press_tracker;
        logic               active_lvl;
        logic [LIMIT_W-1:0] min_press;
        logic [LIMIT_W-1:0] first_lim;
        logic [LIMIT_W-1:0] second_lim;
        logic               held;
        logic [TIME_W-1:0]  edge_ms;
        logic [TIME_W-1:0]  press_len;
        logic [TOTAL_W-1:0] press_total;
        logic [1:0]         hold_flags;
        logic [2:0]         rel_flags;
        t_result            awaited[$];
        int                 failures;
        int                 results_seen;

        function new();
            active_lvl   = RST_ACTIVE_LEVEL;
            min_press    = RST_MIN_PRESS;
            first_lim    = RST_FIRST_LIMIT;
            second_lim   = RST_SECOND_LIMIT;
            held         = 1'b0;
            edge_ms      = '0;
            press_len    = '0;
            press_total  = '0;
            hold_flags   = '0;
            rel_flags    = '0;
            failures     = 0;
            results_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_ACTIVE_LEVEL: active_lvl = value[0];
                CFG_MIN_PRESS:    min_press  = value[LIMIT_W-1:0];
                CFG_FIRST_LIMIT:  first_lim  = value[LIMIT_W-1:0];
                CFG_SECOND_LIMIT: second_lim = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic lvl, logic [TIME_W-1:0] now);
            t_result           r;
            logic [TIME_W-1:0] elapsed;
            if (lvl == active_lvl) begin
                if (!held) begin
                    held        = 1'b1;
                    rel_flags   = '0;
                    press_total = press_total + 1'b1;
                    edge_ms     = now;
                end else begin
                    // sticky until release, even if the elapsed time wraps back
                    elapsed = now - edge_ms;
                    if (elapsed > first_lim)  hold_flags[0] = 1'b1;
                    if (elapsed > second_lim) hold_flags[1] = 1'b1;
                end
            end else if (held) begin
                held       = 1'b0;
                hold_flags = '0;
                press_len  = now - edge_ms;
                edge_ms    = now;
                if (press_len > min_press) begin
                    rel_flags = {press_len > second_lim, press_len > first_lim, 1'b1};
                end else begin
                    // short press takes its count back
                    press_total = press_total - 1'b1;
                end
            end else begin
                rel_flags = '0;
            end
            r.is_pressed          = held;
            r.held_over_first     = hold_flags[0];
            r.held_over_second    = hold_flags[1];
            r.release_valid       = rel_flags[0];
            r.release_over_first  = rel_flags[1];
            r.release_over_second = rel_flags[2];
            r.press_total         = press_total;
            r.last_press_ms       = press_len;
            r.time_in_state_ms    = now - edge_ms;
            awaited.push_back(r);
        endfunction

        task flag_mismatch(string msg);
            failures++;
            if (failures <= MAX_PRINTED)
                $display("MISMATCH at %0t, result %0d: %s", $time, results_seen, msg);
        endtask

        task compare_field(string name, logic [TIME_W-1:0] got_v, logic [TIME_W-1:0] exp_v);
            if (got_v !== exp_v)
                flag_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got_v, exp_v));
        endtask

        task check_result(t_result got);
            t_result exp;
            results_seen++;
            if (awaited.size() == 0) begin
                flag_mismatch("result item with nothing awaited");
            end else begin
                exp = awaited.pop_front();
                compare_field("is_pressed", got.is_pressed, exp.is_pressed);
                compare_field("held_over_first", got.held_over_first, exp.held_over_first);
                compare_field("held_over_second", got.held_over_second, exp.held_over_second);
                compare_field("release_valid", got.release_valid, exp.release_valid);
                compare_field("release_over_first", got.release_over_first,
                              exp.release_over_first);
                compare_field("release_over_second", got.release_over_second,
                              exp.release_over_second);
                compare_field("press_total", got.press_total, exp.press_total);
                compare_field("last_press_ms", got.last_press_ms, exp.last_press_ms);
                compare_field("time_in_state_ms", got.time_in_state_ms, exp.time_in_state_ms);
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    press_tracker      tracker = new();
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                samples_sent = 0;
    int                cycles = 0;
    logic [TIME_W-1:0] clock_ms = '0;

    button_press_duration_classifier_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(t_result'(m_axis_tdata[OUT_BITS-1:0]));
    end

    task automatic send_sample(input logic lvl, input logic [TIME_W-1:0] now);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({now, lvl});
        do @(posedge i_clk); while (!s_axis_tready);
        tracker.note_sample(lvl, now);
        samples_sent++;
    endtask

    // stop sending and let every awaited result come out
    task automatic wait_results_done();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.write_reg(idx, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        case ($urandom_range(0, 3))
            0: return CFG_DATA_W'($urandom_range(0, 100));
            1: return CFG_DATA_W'($urandom_range(0, 3000));
            2: return CFG_DATA_W'($urandom_range(0, 65535));
            default: return CFG_DATA_W'($urandom_range(0, 8000));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] near(input logic [LIMIT_W-1:0] lim);
        // one below, at, or one above a limit; zero minus one wraps to a huge value
        return TIME_W'(lim) + TIME_W'($urandom_range(0, 2)) - 1;
    endfunction

    function automatic logic [TIME_W-1:0] pick_duration();
        case ($urandom_range(0, 7))
            0: return near(tracker.min_press);
            1: return near(tracker.first_lim);
            2: return near(tracker.second_lim);
            3: return TIME_W'($urandom_range(0, 5));
            4: return TIME_W'($urandom_range(0, 70000));
            5: return $urandom;
            default: return TIME_W'($urandom_range(0, 6000));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_elapsed(input logic [TIME_W-1:0] dur);
        case ($urandom_range(0, 4))
            0: return near(tracker.first_lim);
            1: return near(tracker.second_lim);
            2: return $urandom;
            default: return $urandom_range(0, dur);
        endcase
    endfunction

    task automatic press_sequence();
        logic              act;
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] dur;
        act = tracker.active_lvl;
        t0  = clock_ms;
        dur = pick_duration();
        send_sample(act, t0);
        repeat ($urandom_range(0, 5)) send_sample(act, t0 + pick_elapsed(dur));
        // now and then the release never comes
        if ($urandom_range(0, 9) != 0) send_sample(!act, t0 + dur);
        repeat ($urandom_range(0, 2)) send_sample(!act, t0 + dur + $urandom_range(0, 500));
        clock_ms = t0 + dur + $urandom_range(1, 1000);
    endtask

    task automatic run_random_phase(input int quota);
        int start;
        start = samples_sent;
        while (samples_sent - start < quota) begin
            if ($urandom_range(0, 39) == 0) wait_results_done();
            if ($urandom_range(0, 7) == 0)
                send_sample(1'($urandom), $urandom);
            else
                press_sequence();
        end
    endtask

    // reset settings: pressed high, min 50, first 1000, second 5000
    task automatic directed_corners();
        send_sample(1'b0, 32'd0);            // idle sample
        send_sample(1'b1, 32'd100);          // press edge
        send_sample(1'b1, 32'd1100);         // exactly at first limit
        send_sample(1'b1, 32'd1101);         // just over first limit
        send_sample(1'b1, 32'd5100);         // exactly at second limit
        send_sample(1'b1, 32'd5101);         // just over second limit
        send_sample(1'b0, 32'd5101);         // release, all marks
        send_sample(1'b0, 32'd5200);         // pulses clear
        send_sample(1'b1, 32'd5300);
        send_sample(1'b0, 32'd5350);         // exactly min: discarded
        send_sample(1'b1, 32'd5400);
        send_sample(1'b0, 32'd5451);         // just over min: valid, short
        send_sample(1'b1, 32'hFFFF_FF00);    // press just before timestamp wrap
        send_sample(1'b1, 32'h0000_0400);    // elapsed across the wrap
        send_sample(1'b1, 32'hFFFF_FF10);    // smaller elapsed, flags stay
        send_sample(1'b0, 32'h0000_0100);    // release across the wrap
        send_sample(1'b1, 32'hFFFF_FFFF);
        send_sample(1'b0, 32'hFFFF_FFFE);    // largest possible duration
        send_sample(1'b1, 32'hFFFF_FFFF);    // press edge clears pulses
        send_sample(1'b1, 32'hFFFF_FFFF);    // held, pulses stay clear
        send_sample(1'b0, 32'h0000_0001);    // two ms press: discarded
        send_sample(1'b0, 32'h0000_0001);
    endtask

    task automatic configure_phase(input int p);
        case (p)
            0: begin
                set_register(CFG_ACTIVE_LEVEL, 16'hFFFE);   // upper bits dropped
                set_register(CFG_MIN_PRESS, '0);
                set_register(CFG_FIRST_LIMIT, '0);
                set_register(CFG_SECOND_LIMIT, '0);
            end
            1: begin
                set_register(CFG_ACTIVE_LEVEL, 16'h0001);
                set_register(CFG_MIN_PRESS, '1);
                set_register(CFG_FIRST_LIMIT, '1);
                set_register(CFG_SECOND_LIMIT, '1);
            end
            2: begin
                set_register(CFG_ACTIVE_LEVEL, CFG_DATA_W'(RST_ACTIVE_LEVEL));
                set_register(CFG_MIN_PRESS, RST_MIN_PRESS);
                set_register(CFG_FIRST_LIMIT, RST_FIRST_LIMIT);
                set_register(CFG_SECOND_LIMIT, RST_SECOND_LIMIT);
            end
            3: begin
                // second limit below the first
                set_register(CFG_ACTIVE_LEVEL, 16'h0000);
                set_register(CFG_MIN_PRESS, 16'd10);
                set_register(CFG_FIRST_LIMIT, 16'd200);
                set_register(CFG_SECOND_LIMIT, 16'd100);
            end
            default: begin
                set_register(CFG_ACTIVE_LEVEL, 16'($urandom));
                set_register(CFG_MIN_PRESS, pick_limit());
                set_register(CFG_FIRST_LIMIT, pick_limit());
                set_register(CFG_SECOND_LIMIT, pick_limit());
            end
        endcase
        // an index past the register list must change nothing
        set_register(CFG_IDX_W'($urandom_range(SPARE_IDX_LO, SPARE_IDX_HI)), 16'($urandom));
    endtask

    initial begin
        int p;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_corners();
        wait_results_done();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            configure_phase(p);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            run_random_phase(RANDOM_PER_PHASE);
            wait_results_done();
        end

        if (tracker.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
